### src/packet_buffer_descriptor_allocator_macros.svh
// ----------------------------------------------------------------------------
// packet buffer descriptor allocator assertion macros
// concurrent assertion shorthands; empty bodies when synthesizing
// ----------------------------------------------------------------------------
`ifndef PACKET_BUFFER_DESCRIPTOR_ALLOCATOR_MACROS_SVH
`define PACKET_BUFFER_DESCRIPTOR_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define PBDA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define PBDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PBDA_ASSERT_IMPLY(label, ante, cons, msg)
`define PBDA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### src/pbda_pkg.sv
// ----------------------------------------------------------------------------
// pbda_pkg
// shared constants, codes and beat types of the descriptor allocator
// ----------------------------------------------------------------------------
`default_nettype none

package pbda_pkg;

  localparam int MEM_BYTES    = 2048;
  localparam int EP_COUNT     = 8;
  localparam int SLOT_COUNT   = 2 * EP_COUNT;
  localparam int SLOT_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SCAN_W       = SLOT_W + 1;
  localparam int FLOOR_RESET  = 64;

  localparam int ADDR_W       = 12;
  localparam int SIZE_W       = 11;
  localparam int MPS_W        = 10;
  localparam int EP_W         = 3;
  localparam int TYPE_W       = 3;
  localparam int OP_W         = 2;
  localparam int RXW_W        = 16;

  localparam int SMALL_RX_MAX = 62;
  localparam logic [RXW_W-1:0] RX_BLOCK_BASE = 16'h7C00;

  localparam logic [OP_W-1:0] OP_CONFIGURE   = 2'd0;
  localparam logic [OP_W-1:0] OP_DECONFIGURE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR       = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY       = 2'd3;

  localparam logic [TYPE_W-1:0] EPT_CONTROL     = 3'd0;
  localparam logic [TYPE_W-1:0] EPT_ISOCHRONOUS = 3'd1;
  localparam logic [TYPE_W-1:0] EPT_BULK        = 3'd2;
  localparam logic [TYPE_W-1:0] EPT_BULK_DOUBLE = 3'd3;
  localparam logic [TYPE_W-1:0] EPT_INTERRUPT   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [EP_W-1:0]   endpoint;
    logic              is_in;
    logic [TYPE_W-1:0] endpoint_type;
    logic [MPS_W-1:0]  max_packet_size;
  } request_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] slot0_address;
    logic [ADDR_W-1:0] slot1_address;
    logic [RXW_W-1:0]  rx_count_word;
  } result_t;

  typedef struct packed {
    logic              two;
    logic [SIZE_W-1:0] size_a;
    logic              slot_a;
    logic [SIZE_W-1:0] size_b;
    logic              slot_b;
    logic [RXW_W-1:0]  rx_word;
    logic              rx_gate_a;
  } plan_t;

  function automatic logic [SLOT_W-1:0] slot_index(input logic [EP_W-1:0] ep,
                                                   input logic slot);
    return SLOT_W'({ep, slot});
  endfunction

endpackage

`default_nettype wire

### src/pbda_ram.sv
// ----------------------------------------------------------------------------
// pbda_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pbda_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 12
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output      logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/pbda_plan.sv
// ----------------------------------------------------------------------------
// pbda_plan
// turns a configure request into buffer sizes, slots and receive count word
// ----------------------------------------------------------------------------
`default_nettype none

module pbda_plan import pbda_pkg::*; (
  input  wire request_t request,
  output      plan_t    plan
);

  logic [SIZE_W-1:0] even_size;
  logic [SIZE_W-1:0] block_size;
  logic [SIZE_W-1:0] rx_size;
  logic [RXW_W-1:0]  rx_word;
  logic              dbl;
  logic              big;

  always_comb begin
    even_size  = (SIZE_W'(request.max_packet_size) + SIZE_W'(1)) & ~SIZE_W'(1);
    big        = even_size > SIZE_W'(SMALL_RX_MAX);
    block_size = (even_size + SIZE_W'(31)) & ~SIZE_W'(31);
    dbl        = (request.endpoint_type == EPT_ISOCHRONOUS) ||
                 (request.endpoint_type == EPT_BULK_DOUBLE);
    if (big) begin
      rx_size = block_size;
      rx_word = RX_BLOCK_BASE + RXW_W'({block_size, 5'b0});
    end else begin
      rx_size = even_size;
      rx_word = RXW_W'({even_size, 9'b0});
    end
  end

  always_comb begin
    if (request.is_in) begin
      plan.two       = dbl;
      plan.size_a    = even_size;
      plan.slot_a    = 1'b0;
      plan.size_b    = even_size;
      plan.slot_b    = 1'b1;
      plan.rx_word   = '0;
      plan.rx_gate_a = 1'b0;
    end else if (request.endpoint_type == EPT_CONTROL) begin
      // control out: transmit buffer first, then the receive buffer
      plan.two       = 1'b1;
      plan.size_a    = even_size;
      plan.slot_a    = 1'b0;
      plan.size_b    = rx_size;
      plan.slot_b    = 1'b1;
      plan.rx_word   = rx_word;
      plan.rx_gate_a = 1'b1;
    end else begin
      plan.two       = dbl;
      plan.size_a    = rx_size;
      plan.slot_a    = 1'b1;
      plan.size_b    = rx_size;
      plan.slot_b    = 1'b0;
      plan.rx_word   = rx_word;
      plan.rx_gate_a = 1'b0;
    end
  end

endmodule

`default_nettype wire

### src/pbda_seq.sv
// ----------------------------------------------------------------------------
// pbda_seq
// sequencer: table scan for the current top, allocation, write and read back
// ----------------------------------------------------------------------------
`default_nettype none

`include "packet_buffer_descriptor_allocator_macros.svh"

module pbda_seq import pbda_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [OP_W-1:0]   op,
  input  wire logic [EP_W-1:0]   ep,
  input  wire plan_t             plan,
  input  wire logic [ADDR_W-1:0] floor_addr,
  input  wire logic [ADDR_W-1:0] rdata,
  output      logic              busy,
  output      logic              done,
  output      result_t           result,
  output      logic              we,
  output      logic [SLOT_W-1:0] waddr,
  output      logic [ADDR_W-1:0] wdata,
  output      logic [SLOT_W-1:0] raddr
);

  state_t            state;
  state_t            state_next;
  logic [SLOT_COUNT-1:0] valid;
  logic              rd_vld;
  logic              ent_vld_q;
  logic [SCAN_W-1:0] scan_cnt;
  logic [ADDR_W-1:0] top;
  logic [ADDR_W-1:0] top_next;
  logic              step;
  logic [EP_W-1:0]   ep_q;
  plan_t             plan_q;
  result_t           res;

  logic              ep_in_ok;
  logic              scan_more;
  logic [SIZE_W-1:0] cur_size;
  logic              cur_slot;
  logic [ADDR_W-1:0] ent;
  logic [ADDR_W:0]   need;
  logic              alloc_fail;
  logic [ADDR_W-1:0] alloc_addr;
  logic              accept;

  always_comb begin
    accept     = start && (state == ST_IDLE);
    ep_in_ok   = {1'b0, ep} < (EP_W+1)'(EP_COUNT);
    scan_more  = scan_cnt < SCAN_W'(SLOT_COUNT);
    cur_size   = step ? plan_q.size_b : plan_q.size_a;
    cur_slot   = step ? plan_q.slot_b : plan_q.slot_a;
    ent        = ent_vld_q ? rdata : '0;
    top_next   = (rd_vld && (ent != '0) && (ent < top)) ? ent : top;
    need       = {1'b0, floor_addr} + (ADDR_W+1)'(cur_size);
    alloc_fail = ({1'b0, top} < need) || (top == ADDR_W'(cur_size));
    alloc_addr = top - ADDR_W'(cur_size);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (op)
            OP_CONFIGURE:   state_next = ep_in_ok ? ST_SCAN : ST_DONE;
            OP_DECONFIGURE: state_next = ST_DONE;
            OP_CLEAR:       state_next = ST_DONE;
            OP_QUERY:       state_next = ep_in_ok ? ST_RD0 : ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (!scan_more) begin
          state_next = ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        priority if (alloc_fail) begin
          state_next = ST_RD0;
        end else if (!step && plan_q.two) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_RD0;
        end
      end
      ST_RD0:  state_next = ST_RD1;
      ST_RD1:  state_next = ST_RD2;
      ST_RD2:  state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = state != ST_IDLE;
    done  = state == ST_DONE;
    we    = (state == ST_ALLOC) && !alloc_fail;
    waddr = slot_index(ep_q, cur_slot);
    wdata = alloc_addr;
    unique case (state)
      ST_SCAN: raddr = scan_cnt[SLOT_W-1:0];
      ST_RD0:  raddr = slot_index(ep_q, 1'b0);
      ST_RD1:  raddr = slot_index(ep_q, 1'b1);
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == ST_SCAN) && scan_more;
      priority if (accept && (op == OP_CLEAR)) begin
        valid <= '0;
      end else if (accept && (op == OP_DECONFIGURE) && ep_in_ok) begin
        valid[slot_index(ep, 1'b0)] <= 1'b0;
        valid[slot_index(ep, 1'b1)] <= 1'b0;
      end else if (we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_vld_q <= valid[raddr];
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          ep_q              <= ep;
          plan_q            <= plan;
          step              <= 1'b0;
          top               <= ADDR_W'(MEM_BYTES);
          scan_cnt          <= '0;
          res.ok            <= ((op == OP_DECONFIGURE) && ep_in_ok) || (op == OP_CLEAR);
          res.slot0_address <= '0;
          res.slot1_address <= '0;
          res.rx_count_word <= '0;
        end
      end
      ST_SCAN: begin
        top <= top_next;
        if (scan_more) begin
          scan_cnt <= scan_cnt + SCAN_W'(1);
        end
      end
      ST_ALLOC: begin
        if (alloc_fail) begin
          res.ok            <= 1'b0;
          res.rx_count_word <= (!step && plan_q.rx_gate_a) ? '0 : plan_q.rx_word;
        end else begin
          step     <= 1'b1;
          top      <= ADDR_W'(MEM_BYTES);
          scan_cnt <= '0;
          if (step || !plan_q.two) begin
            res.ok            <= 1'b1;
            res.rx_count_word <= plan_q.rx_word;
          end
        end
      end
      ST_RD1:  res.slot0_address <= ent;
      ST_RD2:  res.slot1_address <= ent;
      default: begin
      end
    endcase
  end

  assign result = res;

  `PBDA_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `PBDA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `PBDA_ASSERT_IMPLY(a_scan_bound, state == ST_SCAN, scan_cnt <= SCAN_W'(SLOT_COUNT), "scan overrun")
  `PBDA_ASSERT_IMPLY(a_write_alloc, we, (state == ST_ALLOC) && !alloc_fail, "table write outside allocation")

endmodule

`default_nettype wire

### src/packet_buffer_descriptor_allocator.sv
// ----------------------------------------------------------------------------
// packet_buffer_descriptor_allocator
// descriptor table allocator carving packet buffers down from the memory top
// ----------------------------------------------------------------------------
// clear, deconfigure and a bad endpoint go straight to done; query reads both
//   slots back; configure scans and allocates each buffer, then reads back;
//   a failed buffer ends it. a new beat is taken only while idle; each
//   allocation scans all 16 table entries through the single ram read port
// reset: table empty, floor at 64; done is a one-cycle strobe, no backpressure
`default_nettype none

module packet_buffer_descriptor_allocator import pbda_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output      logic              busy,
  input  wire request_t          request,
  output      logic              done,
  output      result_t           result,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_wdata
);

  logic [ADDR_W-1:0] floor_addr;
  plan_t             plan;
  logic              we;
  logic [SLOT_W-1:0] waddr;
  logic [ADDR_W-1:0] wdata;
  logic [SLOT_W-1:0] raddr;
  logic [ADDR_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_addr <= ADDR_W'(FLOOR_RESET);
    end else if (cfg_we) begin
      floor_addr <= cfg_wdata;
    end
  end

  pbda_plan u_plan (
    .request (request),
    .plan    (plan)
  );

  pbda_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .op         (request.operation),
    .ep         (request.endpoint),
    .plan       (plan),
    .floor_addr (floor_addr),
    .rdata      (rdata),
    .busy       (busy),
    .done       (done),
    .result     (result),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .raddr      (raddr)
  );

  pbda_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire
